// ===== rtl/olr_pkg.sv =====
package olr_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int WIDE_BITS = 128;
    localparam int MULB_BITS = 48;

    typedef logic signed [WIDE_BITS-1:0] wide_t;
    typedef logic signed [MULB_BITS-1:0] mulb_t;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_OFFSET = 3'd1;
    localparam logic [2:0] REQ_MUL    = 3'd2;
    localparam logic [2:0] REQ_DIV    = 3'd3;
    localparam logic [2:0] REQ_MERGE  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FLAT_X   = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_AP_XX,
        S_AP_XY,
        S_RF_M1,
        S_RF_M2,
        S_RF_M3,
        S_RF_M4,
        S_RF_D1,
        S_RF_M5,
        S_RF_D2,
        S_MU_A,
        S_MU_AD,
        S_MU_B,
        S_MU_BD,
        S_DV_A,
        S_DV_B,
        S_RB,
        S_RB_M6,
        S_RB_M7,
        S_RB_M1,
        S_RB_M2,
        S_RB_M8,
        S_RB_M9,
        S_RB_D3,
        S_DONE
    } olr_state_t;

    function automatic wide_t sat_s(input wide_t v, input int bits);
        wide_t mx;
        wide_t mn;
        mx = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
        mn = -mx - wide_t'(1);
        if (v > mx)
            return mx;
        else if (v < mn)
            return mn;
        return v;
    endfunction

    function automatic logic signed [47:0] sat48(input wide_t v);
        wide_t s;
        s = sat_s(v, 48);
        return s[47:0];
    endfunction

    function automatic logic signed [62:0] sat63(input wide_t v);
        wide_t s;
        s = sat_s(v, 63);
        return s[62:0];
    endfunction

    function automatic logic signed [32:0] sat33(input wide_t v);
        wide_t s;
        s = sat_s(v, 33);
        return s[32:0];
    endfunction

    function automatic logic [46:0] satu47(input wide_t v);
        wide_t mx;
        wide_t s;
        mx = (wide_t'(1) <<< 47) - wide_t'(1);
        if (v < 0)
            s = '0;
        else if (v > mx)
            s = mx;
        else
            s = v;
        return s[46:0];
    endfunction

endpackage

// ===== rtl/olr_mul.sv =====
module olr_mul
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  olr_pkg::wide_t a,
    input  olr_pkg::mulb_t b,
    output logic          done,
    output olr_pkg::wide_t p
);

    localparam int CNT_BITS = $clog2(olr_pkg::MULB_BITS + 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic                          neg_reg, neg_next;
    logic [olr_pkg::WIDE_BITS-1:0] ma_reg, ma_next;
    logic [olr_pkg::MULB_BITS-1:0] mb_reg, mb_next;
    logic [olr_pkg::WIDE_BITS-1:0] acc_reg, acc_next;
    olr_pkg::wide_t                p_reg, p_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        acc_reg <= acc_next;
        p_reg   <= p_next;
    end

    // one multiplier bit per cycle, magnitudes, sign fixed at the end
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        acc_next  = acc_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(olr_pkg::MULB_BITS);
            neg_next  = a[olr_pkg::WIDE_BITS-1] ^ b[olr_pkg::MULB_BITS-1];
            ma_next   = a[olr_pkg::WIDE_BITS-1] ? -a : a;
            mb_next   = b[olr_pkg::MULB_BITS-1] ? -b : b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                p_next    = neg_reg ? -olr_pkg::wide_t'(acc_reg) : olr_pkg::wide_t'(acc_reg);
            end
            else
            begin
                if (mb_reg[0])
                    acc_next = acc_reg + ma_reg;
                ma_next  = ma_reg << 1;
                mb_next  = mb_reg >> 1;
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

// ===== rtl/olr_div.sv =====
module olr_div
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  olr_pkg::wide_t n,
    input  olr_pkg::wide_t d,
    output logic           done,
    output olr_pkg::wide_t q
);

    localparam int W        = olr_pkg::WIDE_BITS;
    localparam int CNT_BITS = $clog2(W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [W-1:0]        dm_reg, dm_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [W-1:0]        quo_reg, quo_next;
    olr_pkg::wide_t      q_reg, q_next;
    logic [W:0]          trial;
    logic [W-1:0]        shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        dm_reg  <= dm_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        q_reg   <= q_next;
    end

    assign shifted = {rem_reg[W-2:0], quo_reg[W-1]};
    assign trial   = {1'b0, shifted} - {1'b0, dm_reg};

    // restoring division, one quotient bit per cycle, truncates toward zero
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dm_next   = dm_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(W);
            neg_next  = n[W-1] ^ d[W-1];
            dm_next   = d[W-1] ? -d : d;
            quo_next  = n[W-1] ? -n : n;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_next    = neg_reg ? -olr_pkg::wide_t'(quo_reg) : olr_pkg::wide_t'(quo_reg);
            end
            else
            begin
                if (!trial[W])
                begin
                    rem_next = trial[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ===== rtl/online_linear_regression_top.sv =====
// Work: a request that changes nothing goes straight to the output, while an add point with
// refit, or a multiply or divide with rebuild, runs a chain of serial products and quotients;
// a stalled output holds the finished word, and a result that finds it stalled waits in S_DONE.
// Throughput: one word at a time; the next word is taken the cycle after the result is
// loaded, so the serial multiplier and divider set the pace.
// Reset: rst_n is asynchronous, active low; it clears the count, the sums and the fit to zero.
module online_linear_regression_top
#(
    parameter int SAMPLE_BITS = olr_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = olr_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS   = olr_pkg::FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    req_type,
    input  logic signed [SAMPLE_BITS-1:0] x_sample,
    input  logic signed [SAMPLE_BITS-1:0] y_sample,
    input  logic signed [31:0]            operand,
    input  logic [15:0]                   other_count,
    input  logic signed [31:0]            other_sum_x,
    input  logic [46:0]                   other_sum_x_sq,
    input  logic signed [47:0]            other_sum_y,
    input  logic signed [62:0]            other_sum_xy,
    input  logic signed [47:0]            other_intercept,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [47:0]            intercept,
    output logic signed [47:0]            slope,
    output logic [15:0]                   point_count,
    output logic [1:0]                    status
);

    localparam int CSUM_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

    olr_pkg::olr_state_t state_reg, state_next;
    logic                launched_reg, launched_next;
    logic [1:0]          st_reg, st_next;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic signed [32:0]    acc_x_reg, acc_x_next;
    logic [46:0]           acc_x_sq_reg, acc_x_sq_next;
    logic signed [47:0]    acc_y_reg, acc_y_next;
    logic signed [62:0]    acc_xy_reg, acc_xy_next;
    logic signed [47:0]    coef_a_reg, coef_a_next;
    logic signed [47:0]    coef_b_reg, coef_b_next;
    olr_pkg::wide_t        t0_reg, t0_next;
    olr_pkg::wide_t        t1_reg, t1_next;

    logic [2:0]                    req_reg, req_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic signed [31:0]            f_reg, f_next;
    logic [15:0]                   oc_reg, oc_next;
    logic signed [31:0]            osx_reg, osx_next;
    logic [46:0]                   osxx_reg, osxx_next;
    logic signed [47:0]            osy_reg, osy_next;
    logic signed [62:0]            osxy_reg, osxy_next;
    logic signed [47:0]            oint_reg, oint_next;

    logic                out_valid_reg, out_valid_next;
    logic signed [47:0]  intercept_reg, intercept_next;
    logic signed [47:0]  slope_reg, slope_next;
    logic [15:0]         point_count_reg, point_count_next;
    logic [1:0]          status_reg, status_next;

    logic           mul_start, mul_done;
    olr_pkg::wide_t mul_a, mul_p;
    olr_pkg::mulb_t mul_b;
    logic           div_start, div_done;
    olr_pkg::wide_t div_n, div_d, div_q;

    olr_pkg::wide_t       xw, yf, nw, sxw, syw, fw, den_w;
    logic [CSUM_BITS-1:0] csum;
    logic                 mul_fin, div_fin;

    olr_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    olr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .done  (div_done),
        .q     (div_q)
    );

    assign xw      = olr_pkg::wide_t'(x_reg);
    assign yf      = olr_pkg::wide_t'(y_reg) <<< FRAC_BITS;
    assign nw      = olr_pkg::wide_t'(count_reg);
    assign sxw     = olr_pkg::wide_t'(acc_x_reg);
    assign syw     = olr_pkg::wide_t'(acc_y_reg);
    assign fw      = olr_pkg::wide_t'(f_reg);
    assign den_w   = t0_reg - mul_p;
    assign csum    = CSUM_BITS'(count_reg) + CSUM_BITS'(oc_reg);
    assign mul_fin = launched_reg && mul_done;
    assign div_fin = launched_reg && div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olr_pkg::S_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            acc_x_reg     <= '0;
            acc_x_sq_reg  <= '0;
            acc_y_reg     <= '0;
            acc_xy_reg    <= '0;
            coef_a_reg    <= '0;
            coef_b_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            acc_x_reg     <= acc_x_next;
            acc_x_sq_reg  <= acc_x_sq_next;
            acc_y_reg     <= acc_y_next;
            acc_xy_reg    <= acc_xy_next;
            coef_a_reg    <= coef_a_next;
            coef_b_reg    <= coef_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg          <= st_next;
        t0_reg          <= t0_next;
        t1_reg          <= t1_next;
        req_reg         <= req_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        f_reg           <= f_next;
        oc_reg          <= oc_next;
        osx_reg         <= osx_next;
        osxx_reg        <= osxx_next;
        osy_reg         <= osy_next;
        osxy_reg        <= osxy_next;
        oint_reg        <= oint_next;
        intercept_reg   <= intercept_next;
        slope_reg       <= slope_next;
        point_count_reg <= point_count_next;
        status_reg      <= status_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        launched_next    = launched_reg;
        st_next          = st_reg;
        count_next       = count_reg;
        acc_x_next       = acc_x_reg;
        acc_x_sq_next    = acc_x_sq_reg;
        acc_y_next       = acc_y_reg;
        acc_xy_next      = acc_xy_reg;
        coef_a_next      = coef_a_reg;
        coef_b_next      = coef_b_reg;
        t0_next          = t0_reg;
        t1_next          = t1_reg;
        req_next         = req_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        f_next           = f_reg;
        oc_next          = oc_reg;
        osx_next         = osx_reg;
        osxx_next        = osxx_reg;
        osy_next         = osy_reg;
        osxy_next        = osxy_reg;
        oint_next        = oint_reg;
        intercept_next   = intercept_reg;
        slope_next       = slope_reg;
        point_count_next = point_count_reg;
        status_next      = status_reg;
        mul_start        = 1'b0;
        div_start        = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_n            = '0;
        div_d            = '0;

        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            olr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    x_next     = x_sample;
                    y_next     = y_sample;
                    f_next     = operand;
                    oc_next    = other_count;
                    osx_next   = other_sum_x;
                    osxx_next  = other_sum_x_sq;
                    osy_next   = other_sum_y;
                    osxy_next  = other_sum_xy;
                    oint_next  = other_intercept;
                    state_next = olr_pkg::S_DISPATCH;
                end
            end

            olr_pkg::S_DISPATCH:
            begin
                st_next = olr_pkg::ST_OK;
                unique case (req_reg)
                    olr_pkg::REQ_ADD:
                    begin
                        if (count_reg == {COUNT_BITS{1'b1}})
                        begin
                            st_next    = olr_pkg::ST_FULL;
                            state_next = olr_pkg::S_DONE;
                        end
                        else
                            state_next = olr_pkg::S_AP_XX;
                    end
                    olr_pkg::REQ_OFFSET:
                    begin
                        coef_a_next = olr_pkg::sat48(olr_pkg::wide_t'(coef_a_reg) + fw);
                        state_next  = olr_pkg::S_RB;
                    end
                    olr_pkg::REQ_MUL:
                        state_next = olr_pkg::S_MU_A;
                    olr_pkg::REQ_DIV:
                    begin
                        if (f_reg == '0)
                        begin
                            st_next    = olr_pkg::ST_DIV_ZERO;
                            state_next = olr_pkg::S_DONE;
                        end
                        else
                            state_next = olr_pkg::S_DV_A;
                    end
                    olr_pkg::REQ_MERGE:
                    begin
                        if (oc_reg == '0)
                            state_next = olr_pkg::S_DONE;
                        else if (csum > CSUM_BITS'({COUNT_BITS{1'b1}}))
                        begin
                            st_next    = olr_pkg::ST_FULL;
                            state_next = olr_pkg::S_DONE;
                        end
                        else
                        begin
                            count_next    = COUNT_BITS'(csum);
                            acc_x_next    = olr_pkg::sat33(sxw + olr_pkg::wide_t'(osx_reg));
                            acc_x_sq_next = olr_pkg::satu47(olr_pkg::wide_t'(acc_x_sq_reg)
                                                            + olr_pkg::wide_t'(osxx_reg));
                            acc_y_next    = olr_pkg::sat48(syw + olr_pkg::wide_t'(osy_reg));
                            acc_xy_next   = olr_pkg::sat63(olr_pkg::wide_t'(acc_xy_reg)
                                                           + olr_pkg::wide_t'(osxy_reg));
                            if (csum == CSUM_BITS'(1))
                            begin
                                coef_a_next = oint_reg;
                                coef_b_next = '0;
                                state_next  = olr_pkg::S_DONE;
                            end
                            else
                                state_next = olr_pkg::S_RF_M1;
                        end
                    end
                    default:
                        state_next = olr_pkg::S_DONE;
                endcase
            end

            olr_pkg::S_AP_XX:
            begin
                mul_a = xw;
                mul_b = olr_pkg::mulb_t'(x_reg);
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    count_next    = count_reg + COUNT_BITS'(1);
                    acc_x_next    = olr_pkg::sat33(sxw + xw);
                    acc_x_sq_next = olr_pkg::satu47(olr_pkg::wide_t'(acc_x_sq_reg) + mul_p);
                    state_next    = olr_pkg::S_AP_XY;
                end
            end

            olr_pkg::S_AP_XY:
            begin
                mul_a = yf;
                mul_b = olr_pkg::mulb_t'(x_reg);
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    acc_y_next    = olr_pkg::sat48(syw + yf);
                    acc_xy_next   = olr_pkg::sat63(olr_pkg::wide_t'(acc_xy_reg) + mul_p);
                    if (count_reg == COUNT_BITS'(1))
                    begin
                        coef_a_next = olr_pkg::sat48(yf);
                        coef_b_next = '0;
                        state_next  = olr_pkg::S_DONE;
                    end
                    else
                        state_next = olr_pkg::S_RF_M1;
                end
            end

            olr_pkg::S_RF_M1, olr_pkg::S_RB_M1:
            begin
                mul_a = olr_pkg::wide_t'(acc_x_sq_reg);
                mul_b = olr_pkg::mulb_t'({1'b0, count_reg});
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    t0_next       = mul_p;
                    state_next    = (state_reg == olr_pkg::S_RF_M1) ? olr_pkg::S_RF_M2
                                                                    : olr_pkg::S_RB_M2;
                end
            end

            olr_pkg::S_RF_M2, olr_pkg::S_RB_M2:
            begin
                mul_a = sxw;
                mul_b = olr_pkg::mulb_t'(acc_x_reg);
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    t0_next       = den_w;
                    if (state_reg == olr_pkg::S_RB_M2)
                        state_next = olr_pkg::S_RB_M8;
                    else if (den_w == '0)
                    begin
                        // all x equal: flat slope, intercept is the mean of y
                        coef_b_next = '0;
                        st_next     = olr_pkg::ST_FLAT_X;
                        state_next  = olr_pkg::S_RF_M5;
                    end
                    else
                        state_next = olr_pkg::S_RF_M3;
                end
            end

            olr_pkg::S_RF_M3:
            begin
                mul_a = olr_pkg::wide_t'(acc_xy_reg);
                mul_b = olr_pkg::mulb_t'({1'b0, count_reg});
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    t1_next       = mul_p;
                    state_next    = olr_pkg::S_RF_M4;
                end
            end

            olr_pkg::S_RF_M4:
            begin
                mul_a = syw;
                mul_b = olr_pkg::mulb_t'(acc_x_reg);
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    t1_next       = t1_reg - mul_p;
                    state_next    = olr_pkg::S_RF_D1;
                end
            end

            olr_pkg::S_RF_D1:
            begin
                div_n = t1_reg;
                div_d = t0_reg;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_fin)
                begin
                    launched_next = 1'b0;
                    coef_b_next   = olr_pkg::sat48(div_q);
                    state_next    = olr_pkg::S_RF_M5;
                end
            end

            olr_pkg::S_RF_M5:
            begin
                mul_a = olr_pkg::wide_t'(coef_b_reg);
                mul_b = olr_pkg::mulb_t'(acc_x_reg);
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    t1_next       = syw - mul_p;
                    state_next    = olr_pkg::S_RF_D2;
                end
            end

            olr_pkg::S_RF_D2:
            begin
                div_n = t1_reg;
                div_d = nw;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_fin)
                begin
                    launched_next = 1'b0;
                    coef_a_next   = olr_pkg::sat48(div_q);
                    state_next    = olr_pkg::S_DONE;
                end
            end

            olr_pkg::S_MU_A, olr_pkg::S_MU_B:
            begin
                mul_a = (state_reg == olr_pkg::S_MU_A) ? olr_pkg::wide_t'(coef_a_reg)
                                                      : olr_pkg::wide_t'(coef_b_reg);
                mul_b = olr_pkg::mulb_t'(f_reg);
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    t0_next       = mul_p;
                    state_next    = (state_reg == olr_pkg::S_MU_A) ? olr_pkg::S_MU_AD
                                                                   : olr_pkg::S_MU_BD;
                end
            end

            olr_pkg::S_MU_AD, olr_pkg::S_MU_BD:
            begin
                // drop the fraction bits, truncating toward zero
                div_n = t0_reg;
                div_d = olr_pkg::wide_t'(1) <<< FRAC_BITS;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_fin)
                begin
                    launched_next = 1'b0;
                    if (state_reg == olr_pkg::S_MU_AD)
                    begin
                        coef_a_next = olr_pkg::sat48(div_q);
                        state_next  = olr_pkg::S_MU_B;
                    end
                    else
                    begin
                        coef_b_next = olr_pkg::sat48(div_q);
                        state_next  = olr_pkg::S_RB;
                    end
                end
            end

            olr_pkg::S_DV_A, olr_pkg::S_DV_B:
            begin
                div_n = ((state_reg == olr_pkg::S_DV_A) ? olr_pkg::wide_t'(coef_a_reg)
                                                        : olr_pkg::wide_t'(coef_b_reg))
                        <<< FRAC_BITS;
                div_d = fw;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_fin)
                begin
                    launched_next = 1'b0;
                    if (state_reg == olr_pkg::S_DV_A)
                    begin
                        coef_a_next = olr_pkg::sat48(div_q);
                        state_next  = olr_pkg::S_DV_B;
                    end
                    else
                    begin
                        coef_b_next = olr_pkg::sat48(div_q);
                        state_next  = olr_pkg::S_RB;
                    end
                end
            end

            olr_pkg::S_RB:
            begin
                if (count_reg == '0)
                begin
                    acc_y_next  = '0;
                    acc_xy_next = '0;
                    state_next  = olr_pkg::S_DONE;
                end
                else
                    state_next = olr_pkg::S_RB_M6;
            end

            olr_pkg::S_RB_M6:
            begin
                mul_a = olr_pkg::wide_t'(coef_a_reg);
                mul_b = olr_pkg::mulb_t'({1'b0, count_reg});
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    t1_next       = mul_p;
                    state_next    = olr_pkg::S_RB_M7;
                end
            end

            olr_pkg::S_RB_M7:
            begin
                mul_a = olr_pkg::wide_t'(coef_b_reg);
                mul_b = olr_pkg::mulb_t'(acc_x_reg);
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    acc_y_next    = olr_pkg::sat48(t1_reg + mul_p);
                    state_next    = olr_pkg::S_RB_M1;
                end
            end

            olr_pkg::S_RB_M8:
            begin
                mul_a = t0_reg;
                mul_b = olr_pkg::mulb_t'(coef_b_reg);
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    t1_next       = mul_p;
                    state_next    = olr_pkg::S_RB_M9;
                end
            end

            olr_pkg::S_RB_M9:
            begin
                mul_a = syw;
                mul_b = olr_pkg::mulb_t'(acc_x_reg);
                if (!launched_reg)
                begin
                    mul_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (mul_fin)
                begin
                    launched_next = 1'b0;
                    t1_next       = t1_reg + mul_p;
                    state_next    = olr_pkg::S_RB_D3;
                end
            end

            olr_pkg::S_RB_D3:
            begin
                div_n = t1_reg;
                div_d = nw;
                if (!launched_reg)
                begin
                    div_start     = 1'b1;
                    launched_next = 1'b1;
                end
                else if (div_fin)
                begin
                    launched_next = 1'b0;
                    acc_xy_next   = olr_pkg::sat63(div_q);
                    state_next    = olr_pkg::S_DONE;
                end
            end

            olr_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    intercept_next   = coef_a_reg;
                    slope_next       = coef_b_reg;
                    point_count_next = 16'(count_reg);
                    status_next      = st_reg;
                    state_next       = olr_pkg::S_IDLE;
                end
            end

            default:
                state_next = olr_pkg::S_IDLE;
        endcase
    end

    assign in_stall    = (state_reg != olr_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign intercept   = intercept_reg;
    assign slope       = slope_reg;
    assign point_count = point_count_reg;
    assign status      = status_reg;

endmodule

// ===== dv/online_linear_regression_top_test.sv =====
module online_linear_regression_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int COUNT_MAX      = 65535;

    typedef logic signed [127:0] acc_t;

    typedef struct {
        logic [2:0]          req;
        logic signed [15:0]  x;
        logic signed [15:0]  y;
        logic signed [31:0]  opnd;
        logic [15:0]         o_count;
        logic signed [31:0]  o_sum_x;
        logic [46:0]         o_sum_x_sq;
        logic signed [47:0]  o_sum_y;
        logic signed [62:0]  o_sum_xy;
        logic signed [47:0]  o_intercept;
    } word_t;

    typedef struct {
        logic signed [47:0] a;
        logic signed [47:0] b;
        logic [15:0]        n;
        logic [1:0]         st;
    } fit_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         req_type;
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic signed [31:0] operand;
    logic [15:0]        other_count;
    logic signed [31:0] other_sum_x;
    logic [46:0]        other_sum_x_sq;
    logic signed [47:0] other_sum_y;
    logic signed [62:0] other_sum_xy;
    logic signed [47:0] other_intercept;
    logic               out_valid;
    logic               out_stall;
    logic signed [47:0] intercept;
    logic signed [47:0] slope;
    logic [15:0]        point_count;
    logic [1:0]         status;

    // model of the fit
    int unsigned fit_n;
    acc_t        sum_x, sum_xx, sum_y, sum_xy, coef_a, coef_b;

    fit_t expected_fits[$];
    int   error_count;
    int   idle_cycles;
    bit   calm;

    online_linear_regression_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .x_sample(x_sample), .y_sample(y_sample),
        .operand(operand), .other_count(other_count), .other_sum_x(other_sum_x),
        .other_sum_x_sq(other_sum_x_sq), .other_sum_y(other_sum_y),
        .other_sum_xy(other_sum_xy), .other_intercept(other_intercept),
        .out_valid(out_valid), .out_stall(out_stall),
        .intercept(intercept), .slope(slope), .point_count(point_count),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic acc_t clip_s(acc_t v, int bits);
        acc_t mx;
        acc_t mn;
        mx = (acc_t'(1) <<< (bits - 1)) - acc_t'(1);
        mn = -mx - acc_t'(1);
        if (v > mx)
            return mx;
        if (v < mn)
            return mn;
        return v;
    endfunction

    function automatic acc_t clip_u47(acc_t v);
        acc_t mx;
        mx = (acc_t'(1) <<< 47) - acc_t'(1);
        if (v < 0)
            return '0;
        if (v > mx)
            return mx;
        return v;
    endfunction

    function automatic acc_t x_variance();
        return acc_t'(fit_n) * sum_xx - sum_x * sum_x;
    endfunction

    function automatic logic [1:0] refit_line();
        acc_t den;
        logic [1:0] st;
        den = x_variance();
        st = olr_pkg::ST_OK;
        if (den == 0)
        begin
            coef_b = '0;
            st = olr_pkg::ST_FLAT_X;
        end
        else
            coef_b = clip_s((acc_t'(fit_n) * sum_xy - sum_x * sum_y) / den, 48);
        coef_a = clip_s((sum_y - coef_b * sum_x) / acc_t'(fit_n), 48);
        return st;
    endfunction

    function automatic void rebuild_sums();
        if (fit_n == 0)
        begin
            sum_y = '0;
            sum_xy = '0;
            return;
        end
        sum_y = clip_s(coef_a * acc_t'(fit_n) + coef_b * sum_x, 48);
        sum_xy = clip_s((coef_b * x_variance() + sum_x * sum_y) / acc_t'(fit_n), 63);
    endfunction

    function automatic fit_t update_fit(word_t w);
        fit_t r;
        acc_t f;
        acc_t wx;
        acc_t wy;
        logic [1:0] st;
        st = olr_pkg::ST_OK;
        f = acc_t'(w.opnd);
        case (w.req)
            olr_pkg::REQ_ADD:
            begin
                if (fit_n >= COUNT_MAX)
                    st = olr_pkg::ST_FULL;
                else
                begin
                    wx = acc_t'(w.x);
                    wy = acc_t'(w.y) <<< 16;
                    fit_n++;
                    sum_x = clip_s(sum_x + wx, 33);
                    sum_xx = clip_u47(sum_xx + wx * wx);
                    sum_y = clip_s(sum_y + wy, 48);
                    sum_xy = clip_s(sum_xy + wx * wy, 63);
                    if (fit_n == 1)
                    begin
                        coef_a = clip_s(wy, 48);
                        coef_b = '0;
                    end
                    else
                        st = refit_line();
                end
            end
            olr_pkg::REQ_OFFSET:
            begin
                coef_a = clip_s(coef_a + f, 48);
                rebuild_sums();
            end
            olr_pkg::REQ_MUL:
            begin
                coef_a = clip_s((coef_a * f) / acc_t'(65536), 48);
                coef_b = clip_s((coef_b * f) / acc_t'(65536), 48);
                rebuild_sums();
            end
            olr_pkg::REQ_DIV:
            begin
                if (f == 0)
                    st = olr_pkg::ST_DIV_ZERO;
                else
                begin
                    coef_a = clip_s((coef_a <<< 16) / f, 48);
                    coef_b = clip_s((coef_b <<< 16) / f, 48);
                    rebuild_sums();
                end
            end
            olr_pkg::REQ_MERGE:
            begin
                if (w.o_count != 0)
                begin
                    if (fit_n + w.o_count > COUNT_MAX)
                        st = olr_pkg::ST_FULL;
                    else
                    begin
                        fit_n += w.o_count;
                        sum_x = clip_s(sum_x + acc_t'(w.o_sum_x), 33);
                        sum_xx = clip_u47(sum_xx + acc_t'({1'b0, w.o_sum_x_sq}));
                        sum_y = clip_s(sum_y + acc_t'(w.o_sum_y), 48);
                        sum_xy = clip_s(sum_xy + acc_t'(w.o_sum_xy), 63);
                        if (fit_n == 1)
                        begin
                            coef_a = clip_s(acc_t'(w.o_intercept), 48);
                            coef_b = '0;
                        end
                        else
                            st = refit_line();
                    end
                end
            end
            default: ;
        endcase
        r.a = coef_a[47:0];
        r.b = coef_b[47:0];
        r.n = fit_n[15:0];
        r.st = st;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (calm || p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(3, 1);
        return $urandom_range(80, 10);
    endfunction

    function automatic word_t blank_word(logic [2:0] req);
        word_t w;
        w.req = req;
        w.x = 16'($urandom);
        w.y = 16'($urandom);
        w.opnd = 32'($urandom);
        w.o_count = '0;
        w.o_sum_x = 32'($urandom);
        w.o_sum_x_sq = 47'({$urandom, $urandom});
        w.o_sum_y = 48'({$urandom, $urandom});
        w.o_sum_xy = 63'({$urandom, $urandom});
        w.o_intercept = 48'({$urandom, $urandom});
        return w;
    endfunction

    task automatic send_word(word_t w);
        repeat (pick_gap()) @(negedge clk);
        req_type = w.req;
        x_sample = w.x;
        y_sample = w.y;
        operand = w.opnd;
        other_count = w.o_count;
        other_sum_x = w.o_sum_x;
        other_sum_x_sq = w.o_sum_x_sq;
        other_sum_y = w.o_sum_y;
        other_sum_xy = w.o_sum_xy;
        other_intercept = w.o_intercept;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_fits.push_back(update_fit(w));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        wait (expected_fits.size() == 0);
        @(negedge clk);
    endtask

    task automatic send_point(int x, int y);
        word_t w;
        w = blank_word(olr_pkg::REQ_ADD);
        w.x = 16'(x);
        w.y = 16'(y);
        send_word(w);
    endtask

    task automatic send_coef_op(logic [2:0] req, logic signed [31:0] f);
        word_t w;
        w = blank_word(req);
        w.opnd = f;
        send_word(w);
    endtask

    // empty fit: coefficient ops, unknown requests, empty merge, merge to one point
    task automatic test_empty_fit();
        word_t w;
        send_coef_op(olr_pkg::REQ_OFFSET, 32'sh7fff_ffff);
        send_coef_op(olr_pkg::REQ_MUL, 32'sh8000_0000);
        send_coef_op(olr_pkg::REQ_DIV, 32'sh0000_0003);
        send_coef_op(olr_pkg::REQ_DIV, 32'sh0);
        for (int r = 5; r <= 7; r++)
            send_word(blank_word(3'(r)));
        w = blank_word(olr_pkg::REQ_MERGE);
        send_word(w);
        w = blank_word(olr_pkg::REQ_MERGE);
        w.o_count = 16'd1;
        w.o_sum_x = -32'sd5;
        w.o_sum_x_sq = 47'd25;
        w.o_sum_y = 48'sh8000_0000_0000;
        w.o_sum_xy = '0;
        w.o_intercept = 48'sh8000_0000_0000;
        send_word(w);
    endtask

    // sample extremes, flat x, divide by zero, operand extremes
    task automatic test_points_and_ops();
        send_point(-5, 7);
        send_point(-5, -32768);
        send_point(32767, -32768);
        send_point(-32768, 32767);
        send_point(0, 0);
        send_coef_op(olr_pkg::REQ_OFFSET, 32'sh8000_0000);
        send_coef_op(olr_pkg::REQ_MUL, 32'sh7fff_ffff);
        send_coef_op(olr_pkg::REQ_DIV, 32'sh0);
        send_coef_op(olr_pkg::REQ_DIV, 32'shffff_fffe);
        send_coef_op(olr_pkg::REQ_MUL, 32'sh0001_0000);
        send_coef_op(olr_pkg::REQ_OFFSET, -32'sh0002_8000);
    endtask

    task automatic test_random(int items);
        word_t w;
        int p;
        for (int i = 0; i < items; i++)
        begin
            if (i % 150 == 75)
                calm = ~calm;
            if (i % 200 == 100)
                drain();
            p = $urandom_range(99);
            if (p < 58)
                w = blank_word(olr_pkg::REQ_ADD);
            else if (p < 66)
                w = blank_word(olr_pkg::REQ_OFFSET);
            else if (p < 76)
                w = blank_word(olr_pkg::REQ_MUL);
            else if (p < 86)
                w = blank_word(olr_pkg::REQ_DIV);
            else if (p < 97)
                w = blank_word(olr_pkg::REQ_MERGE);
            else
                w = blank_word(3'($urandom_range(7, 5)));
            if (w.req == olr_pkg::REQ_ADD && $urandom_range(3) != 0)
            begin
                w.x = $signed(16'($urandom_range(200))) - 16'sd100;
                w.y = $signed(16'($urandom_range(2000))) - 16'sd1000;
            end
            // keep factors near one most of the time so the fit stays meaningful
            if ((w.req == olr_pkg::REQ_MUL || w.req == olr_pkg::REQ_DIV)
                && $urandom_range(4) != 0)
                w.opnd = 32'sh0001_0000 + $signed(32'($urandom_range(65536))) - 32'sh8000;
            if (w.req == olr_pkg::REQ_DIV && $urandom_range(15) == 0)
                w.opnd = '0;
            if (w.req == olr_pkg::REQ_MERGE)
            begin
                p = $urandom_range(9);
                if (p == 0)
                    w.o_count = 16'($urandom);
                else if (p != 1)
                begin
                    w.o_count = 16'($urandom_range(8, 1));
                    if ($urandom_range(2) != 0)
                    begin
                        w.o_sum_x = $signed(32'($urandom_range(800))) - 32'sd400;
                        w.o_sum_x_sq = 47'($urandom_range(200000));
                        w.o_sum_y = $signed(48'($urandom_range(1 << 26))) - (48'sd1 <<< 25);
                        w.o_sum_xy = $signed(63'($urandom_range(1 << 30))) - (63'sd1 <<< 29);
                    end
                end
            end
            send_word(w);
        end
        calm = 1'b0;
    endtask

    // fill the count to its top, then adds and merges must be refused
    task automatic test_count_full();
        word_t w;
        drain();
        w = blank_word(olr_pkg::REQ_MERGE);
        w.o_count = 16'(COUNT_MAX - fit_n + 1);
        send_word(w);
        w = blank_word(olr_pkg::REQ_MERGE);
        w.o_count = 16'(COUNT_MAX - fit_n);
        w.o_sum_x = 32'sd1000;
        w.o_sum_x_sq = 47'h7fff_ffff_ffff;
        send_word(w);
        send_point(3, 3);
        w = blank_word(olr_pkg::REQ_MERGE);
        w.o_count = 16'd1;
        send_word(w);
        send_coef_op(olr_pkg::REQ_OFFSET, 32'sh0001_0000);
    endtask

    always @(posedge clk)
    begin
        fit_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_fits.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                e = expected_fits.pop_front();
                if (intercept !== e.a)
                begin
                    $error("intercept: expected %h, got %h", e.a, intercept);
                    error_count++;
                end
                if (slope !== e.b)
                begin
                    $error("slope: expected %h, got %h", e.b, slope);
                    error_count++;
                end
                if (point_count !== e.n)
                begin
                    $error("point_count: expected %0d, got %0d", e.n, point_count);
                    error_count++;
                end
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    error_count++;
                end
            end
        end
    end

    // random receiver stalls, held off during reset and calm stretches
    always @(negedge clk)
    begin
        int p;
        if (!rst_n || calm)
            out_stall = 1'b0;
        else
        begin
            p = $urandom_range(999);
            if (out_stall)
                out_stall = (p >= 150);
            else
                out_stall = (p < 60);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        calm = 1'b0;
        error_count = 0;
        fit_n = 0;
        sum_x = '0;
        sum_xx = '0;
        sum_y = '0;
        sum_xy = '0;
        coef_a = '0;
        coef_b = '0;
        req_type = olr_pkg::REQ_ADD;
        x_sample = '0;
        y_sample = '0;
        operand = '0;
        other_count = '0;
        other_sum_x = '0;
        other_sum_x_sq = '0;
        other_sum_y = '0;
        other_sum_xy = '0;
        other_intercept = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_empty_fit();
        test_points_and_ops();
        test_random(620);
        test_count_full();
        wait (expected_fits.size() == 0);
        repeat (100) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== online_linear_regression_top.f =====
rtl/olr_pkg.sv
rtl/olr_mul.sv
rtl/olr_div.sv
rtl/online_linear_regression_top.sv
dv/online_linear_regression_top_test.sv
